[hdl/brb_pkg.sv]
// ----------------------------------------------------------------------------
// brb_pkg: shared types and constants of the byte ring buffer
// Request codes, field widths and the parameter defaults.
// ----------------------------------------------------------------------------
package brb_pkg;

    localparam int STORE_DEPTH_DEF    = 1024;
    localparam int BYTES_PER_ITEM_DEF = 8;
    localparam int CAP_W              = 11;
    localparam int LEN_W              = 4;
    localparam int TYPE_W             = 3;
    localparam int DATA_W             = 64;
    localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

    typedef enum logic [TYPE_W-1:0] {
        REQ_PARTIAL = 3'd0,
        REQ_STRICT  = 3'd1,
        REQ_OVERWR  = 3'd2,
        REQ_HEAD    = 3'd3,
        REQ_TAIL    = 3'd4,
        REQ_CLEAR   = 3'd5
    } t_req;

    // Request sequencing: wait for a request, merge the bank read data, offer the response.
    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_MERGE = 2'd1,
        ST_RESP  = 2'd2
    } t_state;

endpackage

[hdl/brb_if.sv]
// ----------------------------------------------------------------------------
// brb_req_if / brb_rsp_if: request and response channels
// Valid/ready handshake with the payload of one request or response.
// ----------------------------------------------------------------------------
interface brb_req_if;
    logic                           valid;
    logic                           ready;
    logic [brb_pkg::TYPE_W-1:0]     req_type;
    logic [brb_pkg::LEN_W-1:0]      length;
    logic [brb_pkg::DATA_W-1:0]     data_in;
    modport source (output valid, req_type, length, data_in, input ready);
    modport sink   (input valid, req_type, length, data_in, output ready);
endinterface

interface brb_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [brb_pkg::LEN_W-1:0]      moved_count;
    logic [brb_pkg::DATA_W-1:0]     data_out;
    logic [brb_pkg::CAP_W-1:0]      occupancy;
    logic                           write_refused;
    modport source (output valid, moved_count, data_out, occupancy, write_refused,
                    input ready);
    modport sink   (input valid, moved_count, data_out, occupancy, write_refused,
                     output ready);
endinterface

[hdl/brb_ram.sv]
// ----------------------------------------------------------------------------
// brb_ram: generic single-port-write, single-port-read RAM
// Registered read data.
// ----------------------------------------------------------------------------
module brb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[hdl/brb_lane.sv]
// ----------------------------------------------------------------------------
// brb_lane: one byte lane of the ring
// Maps the lane's byte offset to a slot, picks its bank and bank row.
// ----------------------------------------------------------------------------
module brb_lane #(
    parameter int STORE_DEPTH    = brb_pkg::STORE_DEPTH_DEF,
    parameter int BYTES_PER_ITEM = brb_pkg::BYTES_PER_ITEM_DEF,
    localparam int PW = $clog2(STORE_DEPTH),
    localparam int BW = (BYTES_PER_ITEM > 1) ? $clog2(BYTES_PER_ITEM) : 1,
    localparam int AW = (PW > BW) ? PW : BW,
    localparam int RW = (AW > BW) ? AW - BW : 1
) (
    input  logic [AW-1:0]             i_base,
    input  logic [brb_pkg::LEN_W-1:0] i_offset,
    output logic [BW-1:0]             o_bank,
    output logic [RW-1:0]             o_row
);
    logic [AW-1:0] w_slot;

    // Slots run over a power-of-two address space, so consecutive slots
    // always land in distinct banks.
    always_comb begin
        w_slot = i_base + AW'(i_offset);
        o_bank = w_slot[BW-1:0];
        o_row  = RW'(w_slot >> BW);
    end
endmodule

[hdl/byte_ring_buffer.sv]
// ----------------------------------------------------------------------------
// byte_ring_buffer: byte circular FIFO with partial, strict and overwrite writes
// ----------------------------------------------------------------------------
// Requests enter on req (valid/ready); each carries a kind, a length of up to
// BYTES_PER_ITEM bytes and the write bytes, first byte lowest. One response per
// request leaves on rsp with the bytes moved, read data, occupancy and the
// strict-write refusal flag.
// The store is split into a power-of-two number of byte banks, and the pointers
// run freely over a power-of-two address space; the capacity only bounds the
// occupancy. Two lanes per byte, one for writes and one for reads, map the byte
// to a bank and row, and a merge stage gathers the read bytes.
// A request is accepted in ST_IDLE, the banks return their registered read data
// in ST_MERGE, where the merged response is registered, and it is offered in
// ST_RESP. Only one request is in flight, so a new request is accepted only
// after the response has been taken.
// Reset empties the buffer and sets capacity to 1024. A capacity write empties
// the buffer. While the receiver stalls, the response holds and no new request
// is taken.
// ----------------------------------------------------------------------------
module byte_ring_buffer #(
    parameter int STORE_DEPTH    = brb_pkg::STORE_DEPTH_DEF,
    parameter int BYTES_PER_ITEM = brb_pkg::BYTES_PER_ITEM_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [brb_pkg::CAP_W-1:0]  i_cfg_wdata,
    brb_req_if.sink                    req,
    brb_rsp_if.source                  rsp
);
    localparam int PW = $clog2(STORE_DEPTH);
    localparam int BW = (BYTES_PER_ITEM > 1) ? $clog2(BYTES_PER_ITEM) : 1;
    localparam int NB = 2 ** BW;
    localparam int AW = (PW > BW) ? PW : BW;
    localparam int RW = (AW > BW) ? AW - BW : 1;
    localparam int RD = 2 ** RW;
    localparam int LW = brb_pkg::LEN_W;
    localparam int FW = (PW + 1 > LW) ? PW + 1 : LW;

    logic [brb_pkg::CAP_W-1:0] r_cap;
    logic [AW-1:0] r_wp, n_wp, r_rp, n_rp;
    logic [FW-1:0] r_fill, n_fill;
    brb_pkg::t_state r_state, n_state;

    logic [LW-1:0]  r_moved, n_moved;
    logic           r_refused, n_refused, r_isread, n_isread;
    logic [AW-1:0]  n_base, r_base;
    logic [LW-1:0]  r_sh;

    logic [FW-1:0] w_cap;
    logic [LW-1:0] w_len;
    logic          w_acc;
    brb_pkg::t_req w_kind;

    logic [BW-1:0] w_bank  [BYTES_PER_ITEM];
    logic [RW-1:0] w_row   [BYTES_PER_ITEM];
    logic [BW-1:0] w_wbank [BYTES_PER_ITEM];
    logic [RW-1:0] w_wrow  [BYTES_PER_ITEM];

    logic          w_we    [NB];
    logic [RW-1:0] w_waddr [NB];
    logic [7:0]    w_wdat  [NB];
    logic [RW-1:0] w_raddr [NB];
    logic [7:0]    w_rdat  [NB];
    logic [RW-1:0] r_raddr [NB];

    logic [brb_pkg::DATA_W-1:0] w_dout;

    // Effective capacity: zero acts as one, values past the store clamp.
    always_comb begin
        if (r_cap == '0) begin
            w_cap = FW'(1);
        end else if (32'(r_cap) > STORE_DEPTH) begin
            w_cap = FW'(STORE_DEPTH);
        end else begin
            w_cap = FW'(r_cap);
        end
        w_len = (32'(req.length) > BYTES_PER_ITEM) ? LW'(BYTES_PER_ITEM) : req.length;
        w_kind = brb_pkg::t_req'(req.req_type);
    end

    // Next state of the request sequencing.
    always_comb begin
        n_state = r_state;
        case (r_state)
            brb_pkg::ST_IDLE: begin
                if (req.valid) n_state = brb_pkg::ST_MERGE;
            end
            brb_pkg::ST_MERGE: begin
                n_state = brb_pkg::ST_RESP;
            end
            brb_pkg::ST_RESP: begin
                if (rsp.ready) n_state = brb_pkg::ST_IDLE;
            end
            default: begin
                n_state = brb_pkg::ST_IDLE;
            end
        endcase
    end

    // Handshake outputs of the request sequencing.
    always_comb begin
        req.ready = (r_state == brb_pkg::ST_IDLE);
        rsp.valid = (r_state == brb_pkg::ST_RESP);
    end

    assign w_acc = req.valid && req.ready;

    // Next pointer and fill values for the accepted request.
    always_comb begin
        logic [FW-1:0] room, n, nl;
        logic [AW-1:0] t;
        room      = w_cap - r_fill;
        nl        = FW'(w_len);
        n         = '0;
        t         = '0;
        n_wp      = r_wp;
        n_rp      = r_rp;
        n_fill    = r_fill;
        n_moved   = '0;
        n_refused = 1'b0;
        n_isread  = 1'b0;
        n_base    = r_rp;
        case (w_kind)
            brb_pkg::REQ_PARTIAL, brb_pkg::REQ_STRICT: begin
                if (w_kind == brb_pkg::REQ_STRICT && room < nl) begin
                    n_refused = 1'b1;
                end else begin
                    n = (room < nl) ? room : nl;
                    n_wp    = r_wp + AW'(n);
                    n_fill  = r_fill + n;
                    n_moved = LW'(n);
                end
            end
            brb_pkg::REQ_OVERWR: begin
                t = r_wp + AW'(nl);
                n_wp    = t;
                n_moved = w_len;
                if (nl > room) begin
                    n_fill = w_cap;
                    // Overwritten: the oldest surviving byte is one capacity back.
                    n_rp   = t - AW'(w_cap);
                end else begin
                    n_fill = r_fill + nl;
                end
            end
            brb_pkg::REQ_HEAD: begin
                n = (r_fill < nl) ? r_fill : nl;
                n_rp     = r_rp + AW'(n);
                n_fill   = r_fill - n;
                n_moved  = LW'(n);
                n_isread = 1'b1;
                n_base   = r_rp;
            end
            brb_pkg::REQ_TAIL: begin
                n = (r_fill < nl) ? r_fill : nl;
                t = r_wp - AW'(n);
                n_wp     = t;
                n_fill   = r_fill - n;
                n_moved  = LW'(n);
                n_isread = 1'b1;
                n_base   = t;
            end
            brb_pkg::REQ_CLEAR: begin
                n_wp   = '0;
                n_rp   = '0;
                n_fill = '0;
            end
            default: begin
            end
        endcase
    end

    // Byte lanes: write slots from the write pointer, read slots from the base.
    for (genvar g = 0; g < BYTES_PER_ITEM; g++) begin : g_lane
        brb_lane #(.STORE_DEPTH(STORE_DEPTH), .BYTES_PER_ITEM(BYTES_PER_ITEM)) u_wl (
            .i_base(r_wp), .i_offset(LW'(g)),
            .o_bank(w_wbank[g]), .o_row(w_wrow[g]));
        brb_lane #(.STORE_DEPTH(STORE_DEPTH), .BYTES_PER_ITEM(BYTES_PER_ITEM)) u_rl (
            .i_base(n_base), .i_offset(LW'(g)),
            .o_bank(w_bank[g]), .o_row(w_row[g]));
    end

    // Route lane bytes to banks. Each bank gets at most one byte per request.
    always_comb begin
        for (int b = 0; b < NB; b++) begin
            w_we[b]    = 1'b0;
            w_waddr[b] = '0;
            w_wdat[b]  = '0;
            w_raddr[b] = r_raddr[b];
            for (int l = 0; l < BYTES_PER_ITEM; l++) begin
                if (32'(w_wbank[l]) == b && w_acc && l < 32'(n_moved) &&
                    (w_kind == brb_pkg::REQ_PARTIAL || w_kind == brb_pkg::REQ_STRICT ||
                     w_kind == brb_pkg::REQ_OVERWR)) begin
                    w_we[b]    = 1'b1;
                    w_waddr[b] = w_wrow[l];
                    w_wdat[b]  = req.data_in[8*l +: 8];
                end
                if (32'(w_bank[l]) == b && w_acc) begin
                    w_raddr[b] = w_row[l];
                end
            end
        end
    end

    for (genvar b = 0; b < NB; b++) begin : g_bank
        brb_ram #(.WIDTH(8), .DEPTH(RD)) u_ram (
            .i_clk(i_clk), .i_we(w_we[b]), .i_waddr(w_waddr[b]), .i_wdata(w_wdat[b]),
            .i_raddr(w_raddr[b]), .o_rdata(w_rdat[b]));
    end

    // Merge: lane l takes the byte from the bank its slot fell in.
    always_comb begin
        logic [AW-1:0] s;
        w_dout = '0;
        for (int l = 0; l < BYTES_PER_ITEM; l++) begin
            s = r_base + AW'(l);
            if (r_isread && l < 32'(r_sh)) begin
                w_dout[8*l +: 8] = w_rdat[s[BW-1:0]];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= brb_pkg::CAP_RESET;
            r_wp    <= '0;
            r_rp    <= '0;
            r_fill  <= '0;
            r_state <= brb_pkg::ST_IDLE;
        end else begin
            if (i_cfg_we) begin
                r_cap  <= i_cfg_wdata;
                r_wp   <= '0;
                r_rp   <= '0;
                r_fill <= '0;
            end else if (w_acc) begin
                r_wp   <= n_wp;
                r_rp   <= n_rp;
                r_fill <= n_fill;
            end
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_moved   <= n_moved;
            r_refused <= n_refused;
            r_isread  <= n_isread;
            r_base    <= n_base;
            r_sh      <= n_moved;
            rsp.occupancy <= brb_pkg::CAP_W'(n_fill);
            for (int b = 0; b < NB; b++) r_raddr[b] <= w_raddr[b];
        end
        if (r_state == brb_pkg::ST_MERGE) begin
            rsp.data_out      <= w_dout;
            rsp.moved_count   <= r_moved;
            rsp.write_refused <= r_refused;
        end
    end
endmodule

[hdl/brb_checker.sv]
// ----------------------------------------------------------------------------
// brb_checker: port-level checks of the byte ring buffer
// Watches the request and response channels of the top level.
// ----------------------------------------------------------------------------
module brb_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_req_valid,
    input logic                       i_req_ready,
    input logic                       i_rsp_valid,
    input logic                       i_rsp_ready,
    input logic [brb_pkg::LEN_W-1:0]  i_moved,
    input logic [brb_pkg::CAP_W-1:0]  i_occ,
    input logic                       i_refused
);
    // A response stays offered until it is taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("response dropped while stalled");

    // No request is taken while a response is pending.
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> !i_req_ready)
        else $error("request taken with response pending");

    // A refused write moves nothing.
    a_ref: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_refused |-> i_moved == '0)
        else $error("refused write moved bytes");

    // Moved count never exceeds eight and occupancy never exceeds 1024.
    a_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> i_moved <= 4'd8 && i_occ <= 11'd1024)
        else $error("response field out of range");
endmodule

bind byte_ring_buffer brb_checker u_brb_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_req_valid(req.valid), .i_req_ready(req.ready),
    .i_rsp_valid(rsp.valid), .i_rsp_ready(rsp.ready),
    .i_moved(rsp.moved_count), .i_occ(rsp.occupancy), .i_refused(rsp.write_refused));
